// ===== rtl/isq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isq_pkg;

  localparam int MAX_LANES = 8;
  localparam int RAD_W     = 16;
  localparam int ROOT_W    = 8;
  localparam int STEP_W    = 4;
  localparam int MAX_STEPS = 8;

  localparam logic [STEP_W-1:0] STEP_RESET = 4'd8;
  localparam logic [STEP_W-1:0] STEP_MIN   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MAX   = 4'd8;

  // Per-lane working state carried from cell to cell.
  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] root;
  } isq_lane_t;

endpackage

`default_nettype wire

// ===== rtl/isq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One recurrence step for all lanes, registered. IDX fixes the step's bit.
module isq_cell import isq_pkg::*; #(
  parameter int IDX   = 0,
  parameter int LANES = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic active,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire isq_lane_t up_lane [LANES],
  output logic      dn_valid,
  input  wire logic dn_ready,
  output isq_lane_t dn_lane [LANES]
);

  localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (MAX_STEPS - 1 - IDX));

  isq_lane_t lane_next [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [RAD_W-1:0] t;
      logic             ge;
      t  = up_lane[i].root + BIT;
      ge = (up_lane[i].rem >= t);
      if (active) begin
        lane_next[i].rem  = ge ? (up_lane[i].rem - t) : up_lane[i].rem;
        lane_next[i].root = (up_lane[i].root >> 1) + (ge ? BIT : '0);
      end else begin
        lane_next[i] = up_lane[i];
      end
    end
  end

  // Load when empty or when the downstream cell takes the current transaction.
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_lane <= lane_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/restoring_isqrt_lanes.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Eight-lane restoring integer square root.
//
// Input channel (in_valid/in_ready) carries eight 16-bit unsigned radicands
// per transaction; output channel (out_valid/out_ready) returns eight 8-bit
// roots, one result transaction per input transaction, in order.
// Config channel (cfg_valid/cfg_ready) writes step_count (1..8, 0 acts as 1,
// values above 8 act as 8). cfg_ready is always high; write only while idle.
//
// The datapath is a chain of eight cells, one recurrence step each, all
// lanes side by side. Cells ahead of the entry bit pass data through
// unchanged but still register it, so every radicand passes through all
// eight cell registers. Throughput is one transaction per cycle while the
// receiver keeps out_ready high, set by the single-step cell.
// Each cell has its own valid bit and loads when empty or when its neighbor
// drains, so a stalled receiver lets bubbles collapse and in_ready drops only
// once all eight cells hold data. Reset empties the chain and sets
// step_count to 8. Lanes at or beyond LANE_COUNT read zero.
module restoring_isqrt_lanes import isq_pkg::*; #(
  parameter int LANE_COUNT = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [STEP_W-1:0]  step_count,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [RAD_W-1:0]   radicand_0,
  input  wire logic [RAD_W-1:0]   radicand_1,
  input  wire logic [RAD_W-1:0]   radicand_2,
  input  wire logic [RAD_W-1:0]   radicand_3,
  input  wire logic [RAD_W-1:0]   radicand_4,
  input  wire logic [RAD_W-1:0]   radicand_5,
  input  wire logic [RAD_W-1:0]   radicand_6,
  input  wire logic [RAD_W-1:0]   radicand_7,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ROOT_W-1:0]       root_0,
  output logic [ROOT_W-1:0]       root_1,
  output logic [ROOT_W-1:0]       root_2,
  output logic [ROOT_W-1:0]       root_3,
  output logic [ROOT_W-1:0]       root_4,
  output logic [ROOT_W-1:0]       root_5,
  output logic [ROOT_W-1:0]       root_6,
  output logic [ROOT_W-1:0]       root_7
);

  // Config register, stored raw and clamped on use.
  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] eff_steps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      steps <= step_count;
    end
  end

  always_comb begin
    if (steps < STEP_MIN) begin
      eff_steps = STEP_MIN;
    end else if (steps > STEP_MAX) begin
      eff_steps = STEP_MAX;
    end else begin
      eff_steps = steps;
    end
  end

  logic [RAD_W-1:0] rad_bus  [MAX_LANES];
  logic [ROOT_W-1:0] root_bus [MAX_LANES];

  assign rad_bus[0] = radicand_0;
  assign rad_bus[1] = radicand_1;
  assign rad_bus[2] = radicand_2;
  assign rad_bus[3] = radicand_3;
  assign rad_bus[4] = radicand_4;
  assign rad_bus[5] = radicand_5;
  assign rad_bus[6] = radicand_6;
  assign rad_bus[7] = radicand_7;

  // Chain links: link k feeds cell k; link MAX_STEPS is the output.
  isq_lane_t link_lane  [MAX_STEPS+1][LANE_COUNT];
  logic      link_valid [MAX_STEPS+1];
  logic      link_ready [MAX_STEPS+1];
  logic      cell_active [MAX_STEPS];

  always_comb begin
    for (int i = 0; i < LANE_COUNT; i++) begin
      link_lane[0][i].rem  = rad_bus[i];
      link_lane[0][i].root = '0;
    end
  end

  assign link_valid[0]         = in_valid;
  assign in_ready              = link_ready[0];
  assign out_valid             = link_valid[MAX_STEPS];
  assign link_ready[MAX_STEPS] = out_ready;

  for (genvar k = 0; k < MAX_STEPS; k++) begin : g_cell
    localparam logic [STEP_W:0] K = (STEP_W+1)'(k);

    // Cell k handles bit 4^(7-k); it works only once the entry bit is reached.
    assign cell_active[k] = (K + {1'b0, eff_steps}) >= (STEP_W+1)'(MAX_STEPS);

    isq_cell #(
      .IDX   (k),
      .LANES (LANE_COUNT)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .active   (cell_active[k]),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_lane  (link_lane[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_lane  (link_lane[k+1])
    );
  end

  for (genvar i = 0; i < MAX_LANES; i++) begin : g_out
    if (i < LANE_COUNT) begin : g_used
      assign root_bus[i] = link_lane[MAX_STEPS][i].root[ROOT_W-1:0];
    end else begin : g_unused
      assign root_bus[i] = '0;
    end
  end

  assign root_0 = root_bus[0];
  assign root_1 = root_bus[1];
  assign root_2 = root_bus[2];
  assign root_3 = root_bus[3];
  assign root_4 = root_bus[4];
  assign root_5 = root_bus[5];
  assign root_6 = root_bus[6];
  assign root_7 = root_bus[7];

  // An accepted transaction always lands in the first cell.
  a_first_cell_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> link_valid[1])
    else $error("accepted transaction missing from first cell");

  // An empty first cell must never hold off the sender.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !link_valid[1] |-> in_ready)
    else $error("in_ready low with first cell empty");

  // With all eight steps the remainder is x - r*r, which stays within 2r.
  a_full_root_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (eff_steps == STEP_MAX) |->
      ({1'b0, link_lane[MAX_STEPS][0].rem} <= {link_lane[MAX_STEPS][0].root, 1'b0}))
    else $error("lane 0 remainder exceeds floor-root bound");

endmodule

`default_nettype wire
